[hw/rtl/dssi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssi_pkg: shared types and constants for the interpolating sine generator
// Field widths, scaling constants, and the sequencer state encoding.
// ----------------------------------------------------------------------------
package dssi_pkg;

	localparam int TABLE_BITS_DEF = 8;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int STEP_W   = 24;
	localparam int VOL_W    = 10;
	localparam int SAMPLE_W = 10;
	localparam int PWM_W    = 8;

	// signed operand width of both serial products
	localparam int MC_W = SAMPLE_W + 1;

	// divider: dividend width and quotient digits
	localparam int NUM_W = 22;
	localparam int Q_W   = 11;

	localparam int SAMPLE_MAX    = 1023;
	localparam int SILENCE_LEVEL = 511;
	localparam int MID_OFFSET    = 1023;
	localparam int SCALE_BIAS    = 1046529;
	localparam int SCALE_DIVISOR = 2046;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH_LO,
		ST_FETCH_HI,
		ST_INTERP_GO,
		ST_INTERP,
		ST_SCALE_GO,
		ST_SCALE,
		ST_DIVIDE,
		ST_EMIT
	} dssi_state_t;

endpackage

[hw/rtl/dssi_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssi_ifs: channel interfaces for the interpolating sine generator
// Tick input, sample output and phase step write channel.
// ----------------------------------------------------------------------------
interface dssi_tick_if;
	logic                          valid;
	logic                          ready;
	logic                          active;
	logic [dssi_pkg::VOL_W-1:0]    volume;

	modport source(output valid, active, volume, input ready);
	modport sink(input valid, active, volume, output ready);
endinterface

interface dssi_sample_if;
	logic                            valid;
	logic                            ready;
	logic [dssi_pkg::SAMPLE_W-1:0]   sample_out;
	logic [dssi_pkg::PWM_W-1:0]      pwm_high;
	logic [dssi_pkg::PWM_W-1:0]      pwm_low;

	modport source(output valid, sample_out, pwm_high, pwm_low, input ready);
	modport sink(input valid, sample_out, pwm_high, pwm_low, output ready);
endinterface

interface dssi_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dssi_pkg::STEP_W-1:0]   phase_step;

	modport source(output valid, phase_step, input ready);
	modport sink(input valid, phase_step, output ready);
endinterface

[hw/rtl/dds_sine_generator_interp_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_sine_generator_interp_unit: phase accumulator sine tone generator
// Interpolates a sine table, scales by volume, and splits into PWM bytes.
//
//  channel  dir  payload                            transfer
//  tick     in   active, volume                     valid & ready
//  sample   out  sample_out, pwm_high, pwm_low      valid & ready
//  cfg      in   phase_step                         valid & ready (always ready)
//
// An active tick runs the serial interpolation product (FRAC_BITS steps),
// the serial volume product (10 steps) and the serial divide by 2046
// (11 steps); a silent tick skips the fetch and the interpolation.
// One tick is in work at a time; a new tick is taken while the last sample
// waits in the output register. Reset clears phase, step and control state.
// ----------------------------------------------------------------------------
module dds_sine_generator_interp_unit #(
	parameter int TABLE_BITS = dssi_pkg::TABLE_BITS_DEF,
	parameter int FRAC_BITS  = dssi_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dssi_tick_if.sink            tick,
	dssi_sample_if.source        sample,
	dssi_cfg_if.sink             cfg
);

	localparam int PB = TABLE_BITS + FRAC_BITS;
	localparam int SW = (PB > dssi_pkg::STEP_W) ? PB : dssi_pkg::STEP_W;
	localparam int MW = dssi_pkg::MC_W;
	localparam int VW = dssi_pkg::VOL_W;
	localparam int DW = dssi_pkg::SAMPLE_W;
	localparam int NW = dssi_pkg::NUM_W;
	localparam int QW = dssi_pkg::Q_W;

	typedef struct packed {
		logic tick_ready;
		logic addr_lo;
		logic load_s1;
		logic interp_start;
		logic load_g;
		logic scale_start;
		logic div_start;
		logic load_out;
	} ctl_t;

	dssi_pkg::dssi_state_t state_q, state_d;
	ctl_t                  ctl;

	logic [dssi_pkg::STEP_W-1:0] step_q;
	logic [PB-1:0]               phase_q;
	logic [VW-1:0]               vol_q;
	logic [DW-1:0]               s1_q;
	logic [DW-1:0]               g_q;
	logic [DW-1:0]               sample_q;
	logic                        out_valid_q;

	logic [SW-1:0]         step_ext;
	logic [PB-1:0]         step_w;
	logic [TABLE_BITS-1:0] idx1, idx2, rom_addr;
	logic [DW-1:0]         rom_data;

	logic signed [MW-1:0]      diff;
	logic signed [MW-1:0]      level;
	logic                      a_done, b_done, d_done;
	logic signed [MW:0]        a_hi, b_hi_unused;
	logic signed [MW+FRAC_BITS-1:0] a_prod_unused;
	logic signed [MW+VW-1:0]   b_prod;
	logic signed [NW:0]        num_s;
	logic [NW-1:0]             div_num;
	logic [QW-1:0]             quo;
	logic [DW+1:0]             g_sum;
	logic [DW-1:0]             res;

	always_comb begin
		step_ext = SW'(step_q);
		step_w   = step_ext[PB-1:0];
		idx1     = phase_q[PB-1:FRAC_BITS];
		idx2     = idx1 + TABLE_BITS'(1);
		rom_addr = ctl.addr_lo ? idx1 : idx2;
		diff     = $signed({1'b0, rom_data}) - $signed({1'b0, s1_q});
		level    = MW'($signed({2'b00, g_q, 1'b0}) - (MW+2)'(dssi_pkg::MID_OFFSET));
		g_sum    = {2'b00, s1_q} + (DW+2)'(a_hi);
		num_s    = (NW+1)'(b_prod) + (NW+1)'(dssi_pkg::SCALE_BIAS);
		div_num  = num_s[NW] ? '0 : num_s[NW-1:0];
		res      = quo[QW-1] ? DW'(dssi_pkg::SAMPLE_MAX) : quo[DW-1:0];
	end

	dssi_rom #(
		.TABLE_BITS(TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	dssi_smul #(
		.A_W(MW),
		.B_W(FRAC_BITS)
	) u_interp_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.interp_start),
		.mcand  (diff),
		.mplier (phase_q[FRAC_BITS-1:0]),
		.done   (a_done),
		.hi     (a_hi),
		.prod   (a_prod_unused)
	);

	dssi_smul #(
		.A_W(MW),
		.B_W(VW)
	) u_scale_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.scale_start),
		.mcand  (level),
		.mplier (vol_q),
		.done   (b_done),
		.hi     (b_hi_unused),
		.prod   (b_prod)
	);

	dssi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (div_num),
		.done   (d_done),
		.quo    (quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dssi_pkg::ST_IDLE: begin
				if (tick.valid) begin
					state_d = tick.active ? dssi_pkg::ST_FETCH_LO : dssi_pkg::ST_SCALE_GO;
				end
			end
			dssi_pkg::ST_FETCH_LO:  state_d = dssi_pkg::ST_FETCH_HI;
			dssi_pkg::ST_FETCH_HI:  state_d = dssi_pkg::ST_INTERP_GO;
			dssi_pkg::ST_INTERP_GO: state_d = dssi_pkg::ST_INTERP;
			dssi_pkg::ST_INTERP: begin
				if (a_done) begin
					state_d = dssi_pkg::ST_SCALE_GO;
				end
			end
			dssi_pkg::ST_SCALE_GO:  state_d = dssi_pkg::ST_SCALE;
			dssi_pkg::ST_SCALE: begin
				if (b_done) begin
					state_d = dssi_pkg::ST_DIVIDE;
				end
			end
			dssi_pkg::ST_DIVIDE: begin
				if (d_done) begin
					state_d = dssi_pkg::ST_EMIT;
				end
			end
			dssi_pkg::ST_EMIT: begin
				if (!out_valid_q || sample.ready) begin
					state_d = dssi_pkg::ST_IDLE;
				end
			end
			default: state_d = dssi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			dssi_pkg::ST_IDLE:      ctl.tick_ready   = 1'b1;
			dssi_pkg::ST_FETCH_LO:  ctl.addr_lo      = 1'b1;
			dssi_pkg::ST_FETCH_HI:  ctl.load_s1      = 1'b1;
			dssi_pkg::ST_INTERP_GO: ctl.interp_start = 1'b1;
			dssi_pkg::ST_INTERP:    ctl.load_g       = a_done;
			dssi_pkg::ST_SCALE_GO:  ctl.scale_start  = 1'b1;
			dssi_pkg::ST_SCALE:     ctl.div_start    = b_done;
			dssi_pkg::ST_EMIT:      ctl.load_out     = !out_valid_q || sample.ready;
			default:                ctl              = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dssi_pkg::ST_IDLE;
			step_q      <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				step_q <= cfg.phase_step;
			end
			if (ctl.tick_ready && tick.valid) begin
				phase_q <= tick.active ? phase_q + step_w : '0;
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (sample.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tick_ready && tick.valid) begin
			vol_q <= tick.volume;
			if (!tick.active) begin
				g_q <= DW'(dssi_pkg::SILENCE_LEVEL);
			end
		end
		if (ctl.load_s1) begin
			s1_q <= rom_data;
		end
		if (ctl.load_g) begin
			g_q <= g_sum[DW-1:0];
		end
		if (ctl.load_out) begin
			sample_q <= res;
		end
	end

	assign tick.ready        = ctl.tick_ready;
	assign cfg.ready         = 1'b1;
	assign sample.valid      = out_valid_q;
	assign sample.sample_out = sample_q;
	assign sample.pwm_high   = sample_q[DW-1:2];
	assign sample.pwm_low    = {4{sample_q[1:0]}};

endmodule

[hw/rtl/dssi_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssi_rom: sine table with registered read
// Entry i is floor((1 + sin(2*pi*i/N)) * 1023 / 2), built at elaboration.
// ----------------------------------------------------------------------------
module dssi_rom #(
	parameter int TABLE_BITS = dssi_pkg::TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic [TABLE_BITS-1:0]         addr,
	output logic [dssi_pkg::SAMPLE_W-1:0] data
);

	localparam int TABLE_SIZE = 1 << TABLE_BITS;
	localparam int DW         = dssi_pkg::SAMPLE_W;

	localparam logic [63:0] Q60_ONE     = 64'd1 << 60;
	localparam logic [63:0] Q60_HALF_PI = 64'h1921FB54442D1846;
	localparam logic [63:0] LOW32       = 64'hFFFFFFFF;
	localparam logic [63:0] LOW30       = 64'h3FFFFFFF;

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
		al  = a & LOW32;
		ah  = a >> 32;
		bl  = b & LOW32;
		bh  = b >> 32;
		ll  = al * bl;
		lh  = al * bh;
		hl  = ah * bl;
		hh  = ah * bh;
		mid = (ll >> 32) + (lh & LOW32) + (hl & LOW32);
		lo  = (mid << 32) | (ll & LOW32);
		hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
		return (hi << 4) | (lo >> 60);
	endfunction

	// shift-subtract quotient; divisor stays far below 2^63
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] rem, quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= d) begin
				rem    = rem - d;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] sine_q60(input logic [63:0] a);
		logic [63:0] a2, term, sum, den;
		a2   = mul_q60(a, a);
		term = a;
		sum  = a;
		for (int k = 1; k < 40; k++) begin
			if (term != 64'd0) begin
				den  = 64'(2 * k) * 64'(2 * k + 1);
				term = div_u64(mul_q60(term, a2), den);
				if (k % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		return (sum > Q60_ONE) ? Q60_ONE : sum;
	endfunction

	function automatic logic [DW-1:0] table_entry(input logic [63:0] i);
		logic [63:0] q, r, s, u, hi, lo, a, y;
		q = (4 * i) / TABLE_SIZE;
		r = 4 * i - q * TABLE_SIZE;
		if (r == 64'd0) begin
			s = q[0] ? Q60_ONE : 64'd0;
		end else begin
			a = (Q60_HALF_PI / TABLE_SIZE) * r + ((Q60_HALF_PI % TABLE_SIZE) * r) / TABLE_SIZE;
			if (q[0]) begin
				a = Q60_HALF_PI - a;
			end
			s = sine_q60(a);
		end
		u  = (q < 64'd2) ? Q60_ONE + s : Q60_ONE - s;
		hi = u >> 30;
		lo = u & LOW30;
		y  = (hi * 64'd1023 + ((lo * 64'd1023) >> 30)) >> 31;
		return y[DW-1:0];
	endfunction

	function automatic logic [TABLE_SIZE*DW-1:0] build_table();
		logic [TABLE_SIZE*DW-1:0] tbl;
		tbl = '0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tbl[i*DW +: DW] = table_entry(64'(i));
		end
		return tbl;
	endfunction

	localparam logic [TABLE_SIZE*DW-1:0] SINE_TABLE = build_table();

	always_ff @(posedge clk) begin
		data <= SINE_TABLE[addr*DW +: DW];
	end

endmodule

[hw/rtl/dssi_smul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssi_smul: bit-serial signed by unsigned multiplier
// One multiplier bit per cycle, shift-right form; hi holds floor(P / 2^B_W).
// ----------------------------------------------------------------------------
module dssi_smul #(
	parameter int A_W = dssi_pkg::MC_W,
	parameter int B_W = dssi_pkg::VOL_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [A_W-1:0]     mcand,
	input  logic [B_W-1:0]            mplier,
	output logic                      done,
	output logic signed [A_W:0]       hi,
	output logic signed [A_W+B_W-1:0] prod
);

	localparam int CW = $clog2(B_W + 1);

	logic signed [A_W-1:0] mc_q;
	logic signed [A_W:0]   hi_q;
	logic [B_W-1:0]        lo_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic signed [A_W:0]   sum;

	always_comb begin
		sum = lo_q[0] ? hi_q + (A_W+1)'(mc_q) : hi_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(B_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (run_q) begin
			hi_q <= {sum[A_W], sum[A_W:1]};
			lo_q <= {sum[0], lo_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign hi   = hi_q;
	assign prod = $signed({hi_q[A_W-1:0], lo_q});

endmodule

[hw/rtl/dssi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssi_div: restoring divider by the fixed scale divisor
// One quotient bit per cycle against the aligned divisor.
// ----------------------------------------------------------------------------
module dssi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dssi_pkg::NUM_W-1:0]  num,
	output logic                        done,
	output logic [dssi_pkg::Q_W-1:0]    quo
);

	localparam int NW = dssi_pkg::NUM_W;
	localparam int QW = dssi_pkg::Q_W;
	localparam int CW = $clog2(QW + 1);
	localparam logic [NW-1:0] DIV_ALIGNED = NW'(dssi_pkg::SCALE_DIVISOR) << (QW - 1);

	logic [NW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic          ge;
	logic [NW-1:0] diff;

	always_comb begin
		ge   = rem_q >= DIV_ALIGNED;
		diff = ge ? rem_q - DIV_ALIGNED : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= {diff[NW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[tb/dssi_tone_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssi_tone_checker: sample predictor and in-order scoreboard
// Watches the tick, sample and phase step channels at the rising edge. It
// keeps its own phase accumulator, step and sine table, predicts the sample
// for every tick transfer and compares each sample transfer field by field.
// ----------------------------------------------------------------------------
module dssi_tone_checker
	import dssi_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	dssi_tick_if   tick,
	dssi_sample_if sample,
	dssi_cfg_if    cfg,
	output int     fail_count,
	output int     pending
);

	localparam int        TABLE_LEN   = 1 << TABLE_BITS_DEF;
	localparam int        PHASE_W     = TABLE_BITS_DEF + FRAC_BITS_DEF;
	localparam bit [63:0] Q60_ONE     = 64'h1000_0000_0000_0000;
	localparam bit [63:0] Q60_HALF_PI = 64'h1921_FB54_442D_1846;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_out;
		logic [PWM_W-1:0]    pwm_high;
		logic [PWM_W-1:0]    pwm_low;
	} tone_sample_t;

	logic [SAMPLE_W-1:0] sine_rom [TABLE_LEN];
	logic [STEP_W-1:0]   step_reg;
	logic [PHASE_W-1:0]  tone_phase;
	tone_sample_t        samples_due [$];
	tone_sample_t        due_head;

	function automatic bit [63:0] q60_mul(bit [63:0] a, bit [63:0] b);
		bit [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[123:60];
	endfunction

	function automatic bit [63:0] q60_sine(bit [63:0] a);
		bit [63:0] a2;
		bit [63:0] term;
		bit [63:0] sum;
		bit [63:0] k;
		a2   = q60_mul(a, a);
		term = a;
		sum  = a;
		for (k = 1; k < 40 && term != 0; k++) begin
			term = q60_mul(term, a2) / ((2 * k) * (2 * k + 1));
			if (k[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return (sum > Q60_ONE) ? Q60_ONE : sum;
	endfunction

	function automatic logic [SAMPLE_W-1:0] sine_level(int unsigned i);
		bit [63:0] n;
		bit [63:0] q;
		bit [63:0] r;
		bit [63:0] s;
		bit [63:0] a;
		bit [63:0] u;
		bit [63:0] hi;
		bit [63:0] lo;
		bit [63:0] lvl;
		n = TABLE_LEN;
		q = (64'd4 * i) / n;
		r = 64'd4 * i - q * n;
		if (r == 0) begin
			s = q[0] ? Q60_ONE : 64'd0;
		end else begin
			a = (Q60_HALF_PI / n) * r + ((Q60_HALF_PI % n) * r) / n;
			if (q[0]) begin
				a = Q60_HALF_PI - a;
			end
			s = q60_sine(a);
		end
		u   = (q < 2) ? Q60_ONE + s : Q60_ONE - s;
		hi  = u >> 30;
		lo  = u & 64'h3FFF_FFFF;
		lvl = (hi * 64'd1023 + ((lo * 64'd1023) >> 30)) >> 31;
		return lvl[SAMPLE_W-1:0];
	endfunction

	function automatic tone_sample_t next_tone_sample(logic act, logic [VOL_W-1:0] vol);
		logic [TABLE_BITS_DEF-1:0] idx_lo;
		logic [TABLE_BITS_DEF-1:0] idx_hi;
		longint                    s1;
		longint                    s2;
		longint                    frac;
		longint                    level;
		longint                    gain;
		longint                    scaled;
		tone_sample_t              res;
		if (act) begin
			tone_phase = tone_phase + step_reg;
			idx_lo     = tone_phase[PHASE_W-1 -: TABLE_BITS_DEF];
			idx_hi     = idx_lo + 1'b1;
			frac       = tone_phase[FRAC_BITS_DEF-1:0];
			s1         = sine_rom[idx_lo];
			s2         = sine_rom[idx_hi];
			level      = (s1 * ((longint'(1) << FRAC_BITS_DEF) - frac) + frac * s2)
				>>> FRAC_BITS_DEF;
		end else begin
			tone_phase = '0;
			level      = SILENCE_LEVEL;
		end
		gain   = vol;
		scaled = (2 * level - MID_OFFSET) * gain + SCALE_BIAS;
		if (scaled < 0) begin
			scaled = 0;
		end
		scaled = scaled / SCALE_DIVISOR;
		if (scaled > SAMPLE_MAX) begin
			scaled = SAMPLE_MAX;
		end
		res.sample_out = scaled[SAMPLE_W-1:0];
		res.pwm_high   = PWM_W'(scaled / 4);
		res.pwm_low    = PWM_W'((scaled % 4) * 85);
		return res;
	endfunction

	initial begin
		for (int i = 0; i < TABLE_LEN; i++) begin
			sine_rom[i] = sine_level(i);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_reg   = '0;
			tone_phase = '0;
			samples_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (sample.valid && sample.ready) begin
				if (samples_due.size() == 0) begin
					$error("sample transfer with no expected sample: sample_out %0d",
						sample.sample_out);
					fail_count++;
				end else begin
					due_head = samples_due.pop_front();
					if (due_head.sample_out !== sample.sample_out) begin
						$error("sample_out: expected %0d, actual %0d",
							due_head.sample_out, sample.sample_out);
						fail_count++;
					end
					if (due_head.pwm_high !== sample.pwm_high) begin
						$error("pwm_high: expected %0d, actual %0d",
							due_head.pwm_high, sample.pwm_high);
						fail_count++;
					end
					if (due_head.pwm_low !== sample.pwm_low) begin
						$error("pwm_low: expected %0d, actual %0d",
							due_head.pwm_low, sample.pwm_low);
						fail_count++;
					end
				end
			end
			if (tick.valid && tick.ready) begin
				samples_due.push_back(next_tone_sample(tick.active, tick.volume));
			end
			if (cfg.valid && cfg.ready) begin
				step_reg = cfg.phase_step;
			end
			pending = samples_due.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the interpolating sine generator
// Writes a series of phase steps between idle points, sends directed ticks
// at the volume and step extremes, then random tick runs with bursty idling
// on both channels and one long output hold-off. The checker does the
// prediction and comparison; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb_top;
	import dssi_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 9;
	localparam int DRAIN_CYCLES  = 60;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_TICKS   = 180;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   stall_cycles;
	bit   idle_on;
	bit   hold_req;

	dssi_tick_if   tick_ch ();
	dssi_sample_if sample_ch ();
	dssi_cfg_if    cfg_ch ();

	dds_sine_generator_interp_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.sample (sample_ch),
		.cfg    (cfg_ch)
	);

	dssi_tone_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick_ch),
		.sample     (sample_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	task automatic send_tick(input logic act, input logic [VOL_W-1:0] vol);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		tick_ch.valid  <= 1'b1;
		tick_ch.active <= act;
		tick_ch.volume <= vol;
		do @(posedge clk); while (!tick_ch.ready);
		@(negedge clk);
	endtask

	// drain all samples before touching the step register
	task automatic write_step(input logic [STEP_W-1:0] value);
		tick_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.phase_step <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		sample_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				sample_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				sample_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				sample_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				sample_ch.ready <= 1'b1;
			end else begin
				sample_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((tick_ch.valid && tick_ch.ready) || (sample_ch.valid && sample_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [STEP_W-1:0] step;
		logic              act;
		logic [VOL_W-1:0]  vol;
		arst_n            = 1'b0;
		tick_ch.valid     = 1'b0;
		tick_ch.active    = 1'b0;
		tick_ch.volume    = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.phase_step = '0;
		idle_on           = 1'b1;
		hold_req          = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero step: phase stays at table entry zero; silence at both volume ends
		write_step('0);
		send_tick(1'b1, '1);
		send_tick(1'b1, '0);
		send_tick(1'b0, '1);
		send_tick(1'b0, '0);

		// largest step: phase wraps on every tick from a nonzero phase; silence clears it mid-run
		write_step('1);
		send_tick(1'b1, '1);
		send_tick(1'b1, '1);
		send_tick(1'b1, '1);
		send_tick(1'b1, 10'd1);
		send_tick(1'b0, 10'd512);
		send_tick(1'b1, '1);
		send_tick(1'b1, '1);

		// whole table steps: zero fraction
		write_step(24'h01_0000);
		send_tick(1'b1, '1);
		send_tick(1'b1, '1);
		send_tick(1'b1, '1);

		write_step(24'h40_C000);
		send_tick(1'b1, '1);
		send_tick(1'b1, '1);
		send_tick(1'b1, '1);
		send_tick(1'b1, 10'd512);
		send_tick(1'b1, 10'h2AA);
		send_tick(1'b1, 10'h155);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: step = 24'hFF_FFFF - STEP_W'($urandom_range(0, 255));
				1: step = STEP_W'($urandom_range(1, 255));
				2: step = STEP_W'($urandom());
				3: step = {8'($urandom_range(0, 255)), 16'h0000};
				default: step = STEP_W'($urandom_range(0, 24'h0F_FFFF));
			endcase
			write_step(step);
			if (ph == RANDOM_PHASES - 1) begin
				idle_on = 1'b0;
			end
			for (int n = 0; n < PHASE_TICKS; n++) begin
				if (ph == 2 && n == 40) begin
					hold_req = 1'b1;
				end
				act = ($urandom_range(0, 9) != 0);
				case ($urandom_range(0, 7))
					0: vol = '0;
					1: vol = '1;
					default: vol = VOL_W'($urandom_range(0, 1023));
				endcase
				send_tick(act, vol);
			end
		end

		tick_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
